@@ src/i2c_master_with_register_slave_assert.svh @@
// Assertion macros used by the checker of this block.
`ifndef I2C_MASTER_WITH_REGISTER_SLAVE_ASSERT_SVH
`define I2C_MASTER_WITH_REGISTER_SLAVE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define I2CM_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("i2cm assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define I2CM_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("i2cm assertion failed");

`endif

@@ src/i2cm_pkg.sv @@
package i2cm_pkg;

  localparam int SLAVE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(SLAVE_DEPTH);

  // Bus phase codes
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_READ  = 2'd1;
  localparam logic [1:0] PH_WADDR = 2'd2;
  localparam logic [1:0] PH_WDATA = 2'd3;

  // Register word offsets
  localparam logic [2:0] REG_PRESCALE = 3'd0;
  localparam logic [2:0] REG_ENABLE   = 3'd1;
  localparam logic [2:0] REG_TX       = 3'd2;
  localparam logic [2:0] REG_CTRL     = 3'd3;
  localparam logic [2:0] REG_RX       = 3'd4;
  localparam logic [2:0] REG_STATUS   = 3'd5;

  // Control commands
  localparam logic [31:0] CMD_SEND     = 32'h0000_0010;
  localparam logic [31:0] CMD_READ_ACK = 32'h0000_0020;
  localparam logic [31:0] CMD_READ_NAK = 32'h0000_0028;
  localparam logic [31:0] CMD_STOP     = 32'h0000_0040;
  localparam logic [31:0] CMD_START    = 32'h0000_0090;

  localparam logic [31:0] STAT_BUSY = 32'h0000_0041;
  localparam logic [31:0] STAT_DONE = 32'h0000_0081;

  // Fault codes
  localparam logic [2:0] FLT_NONE     = 3'd0;
  localparam logic [2:0] FLT_BAD_REG  = 3'd1;
  localparam logic [2:0] FLT_PHASE    = 3'd2;
  localparam logic [2:0] FLT_BAD_CMD  = 3'd3;
  localparam logic [2:0] FLT_RX_WRITE = 3'd4;
  localparam logic [2:0] FLT_READ_ACK = 3'd5;

  // Slave clear rule: writing CLR_BYTE to CLR_ADDR zeroes SP_BASE..SP_BASE+2
  localparam logic [ADDR_W-1:0] SP_BASE  = 8'h13;
  localparam logic [ADDR_W-1:0] SP_LAST  = 8'h15;
  localparam logic [ADDR_W-1:0] CLR_ADDR = 8'h19;
  localparam logic [7:0]        CLR_BYTE = 8'h31;

  typedef struct packed {
    logic              wr;
    logic              rd;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } store_req_t;

  function automatic logic [7:0] dflt_byte(input logic [ADDR_W-1:0] a);
    logic [7:0] v;
    unique case (a)
      8'h02: v = 8'h23;  8'h03: v = 8'h60;  8'h04: v = 8'hA3;  8'h07: v = 8'h0C;
      8'h08: v = 8'h9B;  8'h09: v = 8'h99;  8'h0A: v = 8'h2A;  8'h0B: v = 8'hA5;
      8'h11: v = 8'h89;  8'h16: v = 8'h3F;  8'h19: v = 8'h30;  8'h1A: v = 8'h14;
      8'h1D: v = 8'h30;  8'h1E: v = 8'hDA;  8'h21: v = 8'h10;  8'h22: v = 8'h80;
      8'h24: v = 8'hB2;  8'h25: v = 8'h04;  8'h26: v = 8'h64;  8'h27: v = 8'h02;
      8'h28: v = 8'hE9;  8'h2A: v = 8'h93;  8'h2B: v = 8'h1C;  8'h2C: v = 8'h16;
      8'h2D: v = 8'h04;  8'h2E: v = 8'h56;  8'h2F: v = 8'h1F;  8'h30: v = 8'h49;
      8'h31: v = 8'h1D;  8'h32: v = 8'h9F;  8'h33: v = 8'h1E;  8'h34: v = 8'h16;
      8'h35: v = 8'h04;  8'h3D: v = 8'h80;  8'h68: v = 8'h04;  8'h6B: v = 8'h10;
      8'h6C: v = 8'h03;  8'h73: v = 8'h20;  8'h75: v = 8'h60;  8'h76: v = 8'hE4;
      8'h77: v = 8'h20;  8'h78: v = 8'hC1;  8'h7E: v = 8'h02;  8'h87: v = 8'h08;
      8'h89: v = 8'h80;  8'h93: v = 8'h03;  8'h94: v = 8'h60;  8'h95: v = 8'h8F;
      8'h96: v = 8'h30;  8'hA7: v = 8'h0A;  8'hA8: v = 8'h83;  8'hFF: v = 8'h04;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

@@ src/i2cm_in_if.sv @@
interface i2cm_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [2:0]  reg_word;
  logic [31:0] write_data;

  modport source (output valid, kind, reg_word, write_data, input ready);
  modport sink   (input valid, kind, reg_word, write_data, output ready);
endinterface

@@ src/i2cm_out_if.sv @@
interface i2cm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        read_ok;
  logic [2:0]  fault;

  modport source (output valid, read_data, read_ok, fault, input ready);
  modport sink   (input valid, read_data, read_ok, fault, output ready);
endinterface

@@ src/i2cm_store.sv @@
module i2cm_store (
  input  logic                 clk,
  input  logic                 rst,
  input  i2cm_pkg::store_req_t req,
  output logic [7:0]           rdata
);

  logic [7:0]                     mem [i2cm_pkg::SLAVE_DEPTH];
  logic [i2cm_pkg::SLAVE_DEPTH-1:0] vld;
  logic [7:0]                     sp [3];
  logic                           sp_hit;
  logic [1:0]                     sp_idx;
  logic                           clr;

  logic [7:0] mem_q;
  logic [7:0] sp_q;
  logic [7:0] dflt_q;
  logic       sp_hit_q;
  logic       vld_q;

  assign sp_hit = (req.addr >= i2cm_pkg::SP_BASE) && (req.addr <= i2cm_pkg::SP_LAST);
  assign sp_idx = 2'(req.addr - i2cm_pkg::SP_BASE);
  assign clr    = req.wr && (req.addr == i2cm_pkg::CLR_ADDR)
                  && (req.data == i2cm_pkg::CLR_BYTE);

  always_ff @(posedge clk) begin
    if (req.wr && !sp_hit) begin
      mem[req.addr] <= req.data;
    end
    if (req.rd) begin
      mem_q    <= mem[req.addr];
      sp_q     <= sp[sp_idx];
      dflt_q   <= i2cm_pkg::dflt_byte(req.addr);
      sp_hit_q <= sp_hit;
      vld_q    <= vld[req.addr];
    end
  end

  // Entries never written read their device default
  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      sp[0] <= '0;
      sp[1] <= '0;
      sp[2] <= '0;
    end else if (req.wr) begin
      if (sp_hit) begin
        sp[sp_idx] <= req.data;
      end else begin
        vld[req.addr] <= 1'b1;
      end
      if (clr) begin
        sp[0] <= '0;
        sp[1] <= '0;
        sp[2] <= '0;
      end
    end
  end

  assign rdata = sp_hit_q ? sp_q : (vld_q ? mem_q : dflt_q);

endmodule

@@ src/i2c_master_with_register_slave.sv @@
// Each accepted transaction's result is registered in the output register.
// Throughput: one transaction per cycle unless rsp stalls; a NACK read's store read
// is registered in the store, then in rx, and forwarded to an rx read right after.
// Reset (rst, synchronous): state registers clear, phase goes idle; slave store
// entries read their device default until written, tracked by one valid flop per entry.
module i2c_master_with_register_slave (
  input  logic        clk,
  input  logic        rst,
  i2cm_in_if.sink     req,
  i2cm_out_if.source  rsp
);

  logic [31:0] enable_word,   enable_word_next;
  logic [31:0] transmit_word, transmit_word_next;
  logic [7:0]  receive_byte;
  logic [31:0] status_word,   status_word_next;
  logic [1:0]  bus_phase,     bus_phase_next;
  logic [7:0]  slave_pointer, slave_pointer_next;
  logic        rx_pending;

  logic        acc;
  logic [7:0]  rx_cur;
  logic [7:0]  store_rdata;
  logic [31:0] rdata_c;
  logic        ok_c;
  logic [2:0]  fault_c;
  logic        rd_issue;
  i2cm_pkg::store_req_t sreq;

  assign req.ready = !rsp.valid || rsp.ready;
  assign acc       = req.valid && req.ready;
  assign rx_cur    = rx_pending ? store_rdata : receive_byte;

  always_comb begin
    enable_word_next   = enable_word;
    transmit_word_next = transmit_word;
    status_word_next   = status_word;
    bus_phase_next     = bus_phase;
    slave_pointer_next = slave_pointer;
    rdata_c            = '0;
    ok_c               = 1'b0;
    fault_c            = i2cm_pkg::FLT_NONE;
    rd_issue           = 1'b0;
    sreq.wr            = 1'b0;
    sreq.addr          = slave_pointer;
    sreq.data          = transmit_word[7:0];
    if (req.kind) begin
      unique case (req.reg_word)
        i2cm_pkg::REG_PRESCALE: ;
        i2cm_pkg::REG_ENABLE:   enable_word_next   = req.write_data;
        i2cm_pkg::REG_TX:       transmit_word_next = req.write_data;
        i2cm_pkg::REG_RX:       fault_c = i2cm_pkg::FLT_RX_WRITE;
        i2cm_pkg::REG_STATUS:   status_word_next   = req.write_data;
        i2cm_pkg::REG_CTRL: begin
          unique case (req.write_data)
            i2cm_pkg::CMD_SEND: begin
              priority if (bus_phase == i2cm_pkg::PH_WADDR) begin
                status_word_next   = i2cm_pkg::STAT_BUSY;
                slave_pointer_next = transmit_word[7:0];
                bus_phase_next     = i2cm_pkg::PH_WDATA;
              end else if (bus_phase == i2cm_pkg::PH_WDATA) begin
                sreq.wr = 1'b1;
              end else begin
                fault_c = i2cm_pkg::FLT_PHASE;
              end
            end
            i2cm_pkg::CMD_READ_ACK: fault_c = i2cm_pkg::FLT_READ_ACK;
            i2cm_pkg::CMD_READ_NAK: begin
              if (bus_phase == i2cm_pkg::PH_READ) begin
                rd_issue = 1'b1;
              end else begin
                fault_c = i2cm_pkg::FLT_PHASE;
              end
            end
            i2cm_pkg::CMD_STOP: begin
              status_word_next = i2cm_pkg::STAT_DONE;
              bus_phase_next   = i2cm_pkg::PH_IDLE;
            end
            i2cm_pkg::CMD_START: begin
              status_word_next = i2cm_pkg::STAT_BUSY;
              bus_phase_next   = transmit_word[0] ? i2cm_pkg::PH_READ : i2cm_pkg::PH_WADDR;
            end
            default: fault_c = i2cm_pkg::FLT_BAD_CMD;
          endcase
        end
        default: fault_c = i2cm_pkg::FLT_BAD_REG;
      endcase
    end else begin
      unique case (req.reg_word)
        i2cm_pkg::REG_ENABLE: begin
          rdata_c = enable_word;
          ok_c    = 1'b1;
        end
        i2cm_pkg::REG_RX: begin
          rdata_c = {24'd0, rx_cur};
          ok_c    = 1'b1;
        end
        i2cm_pkg::REG_STATUS: begin
          rdata_c = status_word;
          ok_c    = 1'b1;
        end
        default: fault_c = i2cm_pkg::FLT_BAD_REG;
      endcase
    end
    sreq.wr = sreq.wr && acc;
    sreq.rd = rd_issue && acc;
  end

  i2cm_store u_store (
    .clk   (clk),
    .rst   (rst),
    .req   (sreq),
    .rdata (store_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_word   <= '0;
      transmit_word <= '0;
      receive_byte  <= '0;
      status_word   <= '0;
      bus_phase     <= i2cm_pkg::PH_IDLE;
      slave_pointer <= '0;
      rx_pending    <= 1'b0;
      rsp.valid     <= 1'b0;
    end else begin
      // Land the store read in rx once the store has registered it for the NACK read
      rx_pending <= sreq.rd;
      if (rx_pending) begin
        receive_byte <= store_rdata;
      end
      if (acc) begin
        enable_word   <= enable_word_next;
        transmit_word <= transmit_word_next;
        status_word   <= status_word_next;
        bus_phase     <= bus_phase_next;
        slave_pointer <= slave_pointer_next;
      end
      if (acc) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rsp.read_data <= rdata_c;
      rsp.read_ok   <= ok_c;
      rsp.fault     <= fault_c;
    end
  end

endmodule

@@ src/i2cm_checker.sv @@
`include "i2c_master_with_register_slave_assert.svh"

module i2cm_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [31:0] read_data,
  input logic        read_ok,
  input logic [2:0]  fault
);

  `I2CM_ASSERT_NEXT(a_result_follows, req_valid && req_ready, rsp_valid)
  `I2CM_ASSERT_IMP(a_ready_when_empty, !rsp_valid, req_ready)
  `I2CM_ASSERT_IMP(a_fault_clean, rsp_valid && (fault != i2cm_pkg::FLT_NONE),
                   !read_ok && (read_data == 32'd0))
  `I2CM_ASSERT_IMP(a_rx_narrow,
                   rsp_valid && read_ok && (fault == i2cm_pkg::FLT_NONE)
                   && (read_data[31:8] != 24'd0), read_data != 32'd0)
  `I2CM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(read_data) && $stable(fault))

endmodule

bind i2c_master_with_register_slave i2cm_checker u_i2cm_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .read_data (rsp.read_data),
  .read_ok   (rsp.read_ok),
  .fault     (rsp.fault)
);

@@ tb/i2c_master_with_register_slave_tb.sv @@
module i2c_master_with_register_slave_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cm_pkg::*;

  localparam bit KIND_READ  = 1'b0;
  localparam bit KIND_WRITE = 1'b1;

  localparam int RANDOM_ITEMS = 1100;
  localparam int HOLD_CYCLES  = 250;
  localparam int DRAIN_LIMIT  = 2000;

  // Power-on contents of the slave: {address, byte}; all other entries read zero.
  localparam logic [15:0] POWER_ON_BYTES [52] = '{
    16'h0223, 16'h0360, 16'h04A3, 16'h070C, 16'h089B, 16'h0999, 16'h0A2A, 16'h0BA5,
    16'h1189, 16'h163F, 16'h1930, 16'h1A14, 16'h1D30, 16'h1EDA, 16'h2110, 16'h2280,
    16'h24B2, 16'h2504, 16'h2664, 16'h2702, 16'h28E9, 16'h2A93, 16'h2B1C, 16'h2C16,
    16'h2D04, 16'h2E56, 16'h2F1F, 16'h3049, 16'h311D, 16'h329F, 16'h331E, 16'h3416,
    16'h3504, 16'h3D80, 16'h6804, 16'h6B10, 16'h6C03, 16'h7320, 16'h7560, 16'h76E4,
    16'h7720, 16'h78C1, 16'h7E02, 16'h8708, 16'h8980, 16'h9303, 16'h9460, 16'h958F,
    16'h9630, 16'hA70A, 16'hA883, 16'hFF04
  };

  typedef struct packed {
    logic [31:0] read_data;
    logic        read_ok;
    logic [2:0]  fault;
  } response_t;

  class access_model;
    logic [31:0] enable_q;
    logic [31:0] tx_q;
    logic [7:0]  rx_q;
    logic [31:0] status_q;
    logic [1:0]  phase;
    logic [7:0]  pointer;
    logic [7:0]  slave_mem [SLAVE_DEPTH];
    response_t   pending_responses [$];
    int          failures;

    function void reset_state();
      enable_q = '0;
      tx_q     = '0;
      rx_q     = '0;
      status_q = '0;
      phase    = PH_IDLE;
      pointer  = '0;
      failures = 0;
      foreach (slave_mem[i]) slave_mem[i] = '0;
      foreach (POWER_ON_BYTES[i]) slave_mem[POWER_ON_BYTES[i][15:8]] = POWER_ON_BYTES[i][7:0];
    endfunction

    function logic [2:0] issue_command(logic [31:0] cmd);
      logic [7:0] b;
      b = tx_q[7:0];
      case (cmd)
        CMD_SEND: begin
          if (phase == PH_WADDR) begin
            status_q = STAT_BUSY;
            pointer  = b;
            phase    = PH_WDATA;
          end else if (phase == PH_WDATA) begin
            slave_mem[pointer] = b;
            if (pointer == CLR_ADDR && b == CLR_BYTE)
              for (int a = SP_BASE; a <= SP_LAST; a++) slave_mem[a] = '0;
          end else begin
            return FLT_PHASE;
          end
          return FLT_NONE;
        end
        CMD_READ_ACK: return FLT_READ_ACK;
        CMD_READ_NAK: begin
          if (phase != PH_READ) return FLT_PHASE;
          rx_q = slave_mem[pointer];
          return FLT_NONE;
        end
        CMD_STOP: begin
          status_q = STAT_DONE;
          phase    = PH_IDLE;
          return FLT_NONE;
        end
        CMD_START: begin
          status_q = STAT_BUSY;
          phase    = tx_q[0] ? PH_READ : PH_WADDR;
          return FLT_NONE;
        end
        default: return FLT_BAD_CMD;
      endcase
    endfunction

    function void note_access(bit k, logic [2:0] rw, logic [31:0] d);
      response_t r;
      r = '{read_data: '0, read_ok: 1'b0, fault: FLT_NONE};
      if (k == KIND_WRITE) begin
        case (rw)
          REG_PRESCALE: ;
          REG_ENABLE:   enable_q = d;
          REG_TX:       tx_q = d;
          REG_CTRL:     r.fault = issue_command(d);
          REG_RX:       r.fault = FLT_RX_WRITE;
          REG_STATUS:   status_q = d;
          default:      r.fault = FLT_BAD_REG;
        endcase
      end else begin
        case (rw)
          REG_ENABLE: begin r.read_data = enable_q;      r.read_ok = 1'b1; end
          REG_RX:     begin r.read_data = {24'h0, rx_q}; r.read_ok = 1'b1; end
          REG_STATUS: begin r.read_data = status_q;      r.read_ok = 1'b1; end
          default:    r.fault = FLT_BAD_REG;
        endcase
      end
      pending_responses.push_back(r);
    endfunction

    function void check_response(logic [31:0] rd, logic ok, logic [2:0] flt);
      response_t e;
      if (pending_responses.size() == 0) begin
        $error("response with no transaction pending: read_data %h read_ok %b fault %0d",
               rd, ok, flt);
        failures++;
        return;
      end
      e = pending_responses.pop_front();
      if (rd !== e.read_data) begin
        $error("read_data: expected %h, actual %h", e.read_data, rd);
        failures++;
      end
      if (ok !== e.read_ok) begin
        $error("read_ok: expected %b, actual %b", e.read_ok, ok);
        failures++;
      end
      if (flt !== e.fault) begin
        $error("fault: expected %0d, actual %0d", e.fault, flt);
        failures++;
      end
    endfunction
  endclass

  bit clk = 1'b0;
  logic rst = 1'b1;

  i2cm_in_if  req_if ();
  i2cm_out_if rsp_if ();

  i2c_master_with_register_slave DUT (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  access_model model;
  int sent;
  bit quiet;
  bit hold_sink;

  always #2 clk = ~clk;

  task automatic access(input bit k, input logic [2:0] rw, input logic [31:0] d);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.kind       <= k;
    req_if.reg_word   <= rw;
    req_if.write_data <= d;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    model.note_access(k, rw, d);
    sent++;
  endtask

  task automatic write_reg(input logic [2:0] rw, input logic [31:0] d);
    access(KIND_WRITE, rw, d);
  endtask

  // Reads carry random write data; the block must ignore it.
  task automatic read_reg(input logic [2:0] rw);
    access(KIND_READ, rw, $urandom);
  endtask

  function automatic logic [31:0] carry(input logic [7:0] b);
    logic [31:0] w;
    w = $urandom;
    w[7:0] = b;
    return w;
  endfunction

  function automatic logic [7:0] pick_addr();
    case ($urandom_range(0, 3))
      0:       return SP_BASE + 8'($urandom_range(0, 6));
      1:       return POWER_ON_BYTES[$urandom_range(0, 51)][15:8];
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_command();
    case ($urandom_range(0, 5))
      0:       return CMD_SEND;
      1:       return CMD_READ_ACK;
      2:       return CMD_READ_NAK;
      3:       return CMD_STOP;
      4:       return CMD_START;
      default: return $urandom;
    endcase
  endfunction

  task automatic write_burst();
    int n;
    logic [7:0] b;
    n = $urandom_range(0, 4);
    write_reg(REG_TX, carry({7'($urandom), 1'b0}));
    write_reg(REG_CTRL, CMD_START);
    write_reg(REG_TX, carry(pick_addr()));
    write_reg(REG_CTRL, CMD_SEND);
    repeat (n) begin
      b = ($urandom_range(0, 5) == 0) ? CLR_BYTE : 8'($urandom);
      write_reg(REG_TX, carry(b));
      write_reg(REG_CTRL, CMD_SEND);
      if ($urandom_range(0, 3) == 0) read_reg(REG_STATUS);
    end
    // Leave some transfers open so later commands meet an unexpected phase.
    if ($urandom_range(0, 7) != 0) write_reg(REG_CTRL, CMD_STOP);
  endtask

  task automatic read_burst();
    int n;
    n = $urandom_range(1, 3);
    write_reg(REG_TX, carry({7'($urandom), 1'b0}));
    write_reg(REG_CTRL, CMD_START);
    write_reg(REG_TX, carry(pick_addr()));
    write_reg(REG_CTRL, CMD_SEND);
    write_reg(REG_CTRL, CMD_STOP);
    write_reg(REG_TX, carry({7'($urandom), 1'b1}));
    write_reg(REG_CTRL, CMD_START);
    repeat (n) begin
      write_reg(REG_CTRL, ($urandom_range(0, 7) == 0) ? CMD_READ_ACK : CMD_READ_NAK);
      read_reg(REG_RX);
    end
    if ($urandom_range(0, 3) == 0) read_reg(REG_STATUS);
    if ($urandom_range(0, 7) != 0) write_reg(REG_CTRL, CMD_STOP);
  endtask

  task automatic noise();
    logic [2:0] rw;
    repeat ($urandom_range(1, 4)) begin
      rw = 3'($urandom);
      if ($urandom_range(0, 1) == 0)
        read_reg(rw);
      else
        write_reg(rw, (rw == REG_CTRL) ? pick_command() : $urandom);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready)
      model.check_response(rsp_if.read_data, rsp_if.read_ok, rsp_if.fault);
  end

  // Response side: random stalls, plus one long hold-off requested by the stimulus.
  initial begin
    forever begin
      if (hold_sink) begin
        hold_sink = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        rsp_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int directed;
    int drain;
    bit pressure_done;
    req_if.valid      = 1'b0;
    req_if.kind       = KIND_READ;
    req_if.reg_word   = REG_PRESCALE;
    req_if.write_data = '0;
    model = new();
    model.reset_state();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset values and every register word, readable or not.
    for (int r = 0; r < 8; r++) read_reg(3'(r));
    write_reg(REG_PRESCALE, 32'hFFFF_FFFF);
    write_reg(REG_ENABLE, 32'hFFFF_FFFF);
    read_reg(REG_ENABLE);
    write_reg(REG_STATUS, 32'hA5A5_5A5A);
    write_reg(REG_RX, 32'hFFFF_FFFF);
    write_reg(3'd6, 32'h0);
    write_reg(3'd7, 32'hFFFF_FFFF);
    // Unknown command, read with ack, and byte commands while idle.
    write_reg(REG_CTRL, 32'hFFFF_FFFF);
    write_reg(REG_CTRL, CMD_READ_ACK);
    write_reg(REG_CTRL, CMD_SEND);
    write_reg(REG_CTRL, CMD_READ_NAK);
    // Write 0x31 to register 0x19 to trigger the clear, then read it back.
    write_reg(REG_TX, 32'h0);
    write_reg(REG_CTRL, CMD_START);
    write_reg(REG_TX, {24'hFFFFFF, CLR_ADDR});
    write_reg(REG_CTRL, CMD_SEND);
    write_reg(REG_TX, {24'hFFFFFF, CLR_BYTE});
    write_reg(REG_CTRL, CMD_SEND);
    write_reg(REG_CTRL, CMD_STOP);
    write_reg(REG_TX, 32'h1);
    write_reg(REG_CTRL, CMD_START);
    write_reg(REG_CTRL, CMD_READ_NAK);
    read_reg(REG_RX);
    write_reg(REG_CTRL, CMD_SEND);
    write_reg(REG_CTRL, CMD_STOP);
    read_reg(REG_STATUS);
    directed = sent;

    pressure_done = 1'b0;
    while (sent < directed + RANDOM_ITEMS) begin
      if (!pressure_done && sent >= directed + 300) begin
        hold_sink = 1'b1;
        pressure_done = 1'b1;
      end
      if (sent >= directed + RANDOM_ITEMS - 150) quiet = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: write_burst();
        4, 5, 6:    read_burst();
        default:    noise();
      endcase
    end
    req_if.valid <= 1'b0;

    drain = 0;
    while (model.pending_responses.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (5) @(posedge clk);
    if (model.pending_responses.size() != 0) begin
      $error("%0d responses never arrived", model.pending_responses.size());
      model.failures++;
    end

    if (model.failures == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
